[rtl/afic_pkg.sv]
// Package for the assembly function instruction classifier.
// Holds shared constants, character helpers and the front-to-back line record type.
// Used by every module of the block.
package afic_pkg;

  localparam int MAX_NAME_CHARS   = 16;
  localparam int OPCODE_CHARS     = 15;
  localparam int OPCODE_OUT_CHARS = 7;
  localparam int COUNT_BITS       = 16;
  localparam int OPLEN_BITS       = $clog2(OPCODE_CHARS + 1);
  localparam int LINE_SAT         = 31;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_NAME_LOW  = 2'd0;
  localparam logic [1:0] REG_NAME_HIGH = 2'd1;
  localparam logic [1:0] REG_NAME_LEN  = 2'd2;
  localparam logic [1:0] REG_OP_LIMIT  = 2'd3;

  // Opcode classes.
  localparam logic [1:0] CLS_MOVE  = 2'd0;
  localparam logic [1:0] CLS_ARITH = 2'd1;
  localparam logic [1:0] CLS_CTRL  = 2'd2;
  localparam logic [1:0] CLS_OTHER = 2'd3;

  typedef enum logic [1:0] {
    SCAN_SEARCH = 2'd0,
    SCAN_BODY   = 2'd1,
    SCAN_DONE   = 2'd2
  } scan_phase_t;

  typedef enum logic [1:0] {
    OP_SKIP    = 2'd0,
    OP_COLLECT = 2'd1,
    OP_DONE    = 2'd2,
    OP_NONE    = 2'd3
  } op_phase_t;

  typedef logic [OPCODE_CHARS-1:0][7:0] op_buf_t;

  // One finished body line, handed from the front part to the back part.
  typedef struct packed {
    logic                  count_insn;   // tab-led nonblank line
    logic                  has_opcode;   // opcode to classify
    logic [OPLEN_BITS-1:0] op_len;
    op_buf_t               op_buf;
    logic                  summary;      // final byte: send summary afterwards
    logic                  found;        // label line was found
  } line_rec_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic size_suffix(input logic [7:0] c);
    return c == "q" || c == "l" || c == "w" || c == "b";
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

endpackage

[rtl/afic_front.sv]
// Front part: scans text bytes, finds the label, collects per-line opcode data.
// Depends on afic_pkg. Pushes one line record per body line or final byte.
module afic_front
  import afic_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_text_byte,
  input  logic             in_last_byte,
  input  logic [63:0]      name_low,
  input  logic [63:0]      name_high,
  input  logic [4:0]       name_len,
  input  logic             q_full,
  output logic             q_push,
  output line_rec_t        q_data
);

  scan_phase_t           scan_r, scan_nxt;
  logic [4:0]            llen_r, llen_nxt;
  logic                  match_r, match_nxt;
  logic                  lbl_ok_r, lbl_ok_nxt;
  logic [7:0]            first_r, first_nxt;
  logic                  dotl_r, dotl_nxt;
  logic [1:0]            cbh_r, cbh_nxt;
  logic                  blank_r, blank_nxt;
  op_phase_t             oph_r, oph_nxt;
  logic                  dir_r, dir_nxt;
  op_buf_t               buf_r, buf_nxt;
  logic [OPLEN_BITS-1:0] olen_r, olen_nxt;

  logic       acc, is_nl, do_end;
  logic [4:0] nlen;
  logic [7:0] c, nbyte;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign c        = in_text_byte;
  assign is_nl    = (c == 8'h0a);
  assign do_end   = is_nl || in_last_byte;
  assign nlen     = (name_len > 5'(MAX_NAME_CHARS)) ? 5'(MAX_NAME_CHARS) : name_len;
  assign nbyte    = llen_r[3] ? name_high[{llen_r[2:0], 3'b000} +: 8]
                              : name_low[{llen_r[2:0], 3'b000} +: 8];

  // Per-byte line state update, then line end evaluation.
  always_comb begin
    logic      lbl, body_line;
    scan_phase_t sc;
    scan_nxt   = scan_r;
    llen_nxt   = llen_r;
    match_nxt  = match_r;
    lbl_ok_nxt = lbl_ok_r;
    first_nxt  = first_r;
    dotl_nxt   = dotl_r;
    cbh_nxt    = cbh_r;
    blank_nxt  = blank_r;
    oph_nxt    = oph_r;
    dir_nxt    = dir_r;
    buf_nxt    = buf_r;
    olen_nxt   = olen_r;
    q_push     = 1'b0;
    q_data     = '0;
    lbl        = 1'b0;
    body_line  = 1'b0;
    sc         = scan_r;
    if (!is_nl) begin
      if (scan_r == SCAN_SEARCH) begin
        if (llen_r < nlen) begin
          if (c != nbyte) match_nxt = 1'b0;
        end else if (llen_r == nlen) begin
          lbl_ok_nxt = match_r && c == ":";
        end else if (llen_r == nlen + 5'd1) begin
          if (c != 8'h0d) lbl_ok_nxt = 1'b0;
        end
      end else if (scan_r == SCAN_BODY) begin
        if (llen_r == 5'd0) first_nxt = c;
        if (llen_r == 5'd1) dotl_nxt = (first_r == ".") && (c == "L");
        if (cbh_r == 2'd0) begin
          if (c == ":") cbh_nxt = 2'd1;
          else if (c == "#") cbh_nxt = 2'd2;
        end
        if (!is_space(c)) blank_nxt = 1'b0;
        if (oph_r == OP_SKIP) begin
          if (c == 8'h20 || c == 8'h09) begin
          end else if (is_alpha(c)) begin
            buf_nxt[0] = c;
            olen_nxt   = OPLEN_BITS'(1);
            oph_nxt    = OP_COLLECT;
          end else begin
            dir_nxt = (c == ".") || (c == "#");
            oph_nxt = OP_NONE;
          end
        end else if (oph_r == OP_COLLECT) begin
          if ((is_alnum(c) || c == "_") && olen_r < OPLEN_BITS'(OPCODE_CHARS)) begin
            buf_nxt[olen_r] = c;
            olen_nxt = olen_r + 1'b1;
          end else begin
            oph_nxt = OP_DONE;
          end
        end
      end
      if (llen_r != 5'(LINE_SAT)) llen_nxt = llen_r + 5'd1;
    end
    if (do_end) begin
      if (scan_r == SCAN_SEARCH) begin
        if (lbl_ok_nxt) sc = SCAN_BODY;
      end else if (scan_r == SCAN_BODY && llen_nxt != 5'd0) begin
        lbl = first_nxt != 8'h09 && cbh_nxt == 2'd1;
        if (lbl) begin
          if (!dotl_nxt) sc = SCAN_DONE;
        end else if (!dir_nxt) begin
          body_line = 1'b1;
        end
      end
      q_data.count_insn = body_line && !blank_nxt && first_nxt == 8'h09;
      q_data.has_opcode = body_line && (oph_nxt == OP_COLLECT || oph_nxt == OP_DONE)
                          && olen_nxt != '0;
      q_data.op_len     = olen_nxt;
      q_data.op_buf     = buf_nxt;
      q_data.summary    = in_last_byte;
      q_data.found      = sc != SCAN_SEARCH;
      q_push            = acc && (body_line || in_last_byte);
      scan_nxt   = in_last_byte ? SCAN_SEARCH : sc;
      llen_nxt   = '0;
      match_nxt  = 1'b1;
      lbl_ok_nxt = 1'b0;
      first_nxt  = '0;
      dotl_nxt   = 1'b0;
      cbh_nxt    = 2'd0;
      blank_nxt  = 1'b1;
      oph_nxt    = OP_SKIP;
      dir_nxt    = 1'b0;
      olen_nxt   = '0;
    end
  end

  // Line state registers; the opcode buffer is payload only.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r   <= SCAN_SEARCH;
      llen_r   <= '0;
      match_r  <= 1'b1;
      lbl_ok_r <= 1'b0;
      first_r  <= '0;
      dotl_r   <= 1'b0;
      cbh_r    <= 2'd0;
      blank_r  <= 1'b1;
      oph_r    <= OP_SKIP;
      dir_r    <= 1'b0;
      olen_r   <= '0;
    end else if (acc) begin
      scan_r   <= scan_nxt;
      llen_r   <= llen_nxt;
      match_r  <= match_nxt;
      lbl_ok_r <= lbl_ok_nxt;
      first_r  <= first_nxt;
      dotl_r   <= dotl_nxt;
      cbh_r    <= cbh_nxt;
      blank_r  <= blank_nxt;
      oph_r    <= oph_nxt;
      dir_r    <= dir_nxt;
      olen_r   <= olen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) buf_r <= buf_nxt;
  end

  // The opcode length never passes the buffer depth.
  a_olen_range: assert property (@(posedge clk) disable iff (!rst_n)
    olen_r <= OPLEN_BITS'(OPCODE_CHARS)) else $error("opcode length overflow");
  // A line being collected in the body always holds a first character.
  a_collect_len: assert property (@(posedge clk) disable iff (!rst_n)
    oph_r == OP_COLLECT |-> olen_r != '0) else $error("collecting with no chars");
  // Nothing is pushed while the queue is full.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push) else $error("push into full queue");

endmodule

[rtl/afic_queue.sv]
// Short queue of line records between the front and back parts.
// Depends on afic_pkg for the record type.
module afic_queue
  import afic_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  line_rec_t push_data,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output line_rec_t head
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  line_rec_t      mem_r [DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;

  assign full  = cnt_r == (AW+1)'(DEPTH);
  assign empty = cnt_r == '0;
  assign head  = mem_r[rp_r];

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("queue underflow");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH)) else $error("queue count out of range");

endmodule

[rtl/afic_back.sv]
// Back part: strips suffixes, classifies opcodes, keeps counters, drives results.
// Depends on afic_pkg. Pops line records from the queue.
module afic_back
  import afic_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [15:0]           op_limit,
  input  logic                  q_empty,
  input  line_rec_t             q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_item_kind,
  output logic [55:0]           out_opcode_text,
  output logic [1:0]            out_opcode_class,
  output logic                  out_function_found,
  output logic [15:0]           out_instruction_count,
  output logic [15:0]           out_mov_count,
  output logic [15:0]           out_arith_count,
  output logic [15:0]           out_control_count,
  output logic [15:0]           out_other_count,
  output logic [15:0]           out_opcode_total,
  output logic                  out_last_item
);

  logic [COUNT_BITS-1:0] insn_r, mov_r, ari_r, ctl_r, oth_r, tot_r, emit_r;
  // Second half of a record that gives both an opcode and the summary.
  logic                  pend_r;

  logic                  ov_r;
  logic                  kind_r, found_r, last_r;
  logic [55:0]           text_r;
  logic [1:0]            cls_r;
  logic [15:0]           ic_r, mc_r, ac_r, cc_r, oc_r, tc_r;

  logic                  slot_free;
  logic [OPLEN_BITS-1:0] len1, len;
  logic [1:0]            cls;
  logic                  emit_op;
  logic [55:0]           text;
  logic                  take, fin;
  logic [COUNT_BITS-1:0] insn_upd, mov_upd, ari_upd, ctl_upd, oth_upd, tot_upd, emit_upd;

  assign slot_free = !ov_r || !out_stall;

  // Suffix stripping, applied up to twice.
  always_comb begin
    len1 = q_head.op_len;
    if (len1 > OPLEN_BITS'(3) && size_suffix(q_head.op_buf[len1 - 1'b1])) len1 = len1 - 1'b1;
    len = len1;
    if (len > OPLEN_BITS'(3) && size_suffix(q_head.op_buf[len - 1'b1])) len = len - 1'b1;
  end

  function automatic logic op_is(input op_buf_t b, input logic [OPLEN_BITS-1:0] l,
                                 input logic [39:0] s, input int n);
    logic ok;
    ok = (l == OPLEN_BITS'(n));
    for (int i = 0; i < 5; i++) begin
      if (i < n && b[i] != s[8*(n-1-i) +: 8]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic op_pre(input op_buf_t b, input logic [OPLEN_BITS-1:0] l,
                                  input logic [39:0] s, input int n);
    logic ok;
    ok = (l >= OPLEN_BITS'(n));
    for (int i = 0; i < 5; i++) begin
      if (i < n && b[i] != s[8*(n-1-i) +: 8]) ok = 1'b0;
    end
    return ok;
  endfunction

  // Opcode classification.
  always_comb begin
    op_buf_t b;
    b = q_head.op_buf;
    if (op_is(b, len, "mov", 3) || op_is(b, len, "movz", 4) || op_is(b, len, "movs", 4) ||
        op_is(b, len, "lea", 3) || op_is(b, len, "xchg", 4) || op_is(b, len, "push", 4) ||
        op_is(b, len, "pop", 3) || op_pre(b, len, "cmov", 4) ||
        op_pre(b, len, "movzb", 5) || op_pre(b, len, "movsb", 5) ||
        op_pre(b, len, "movzw", 5) || op_pre(b, len, "movsw", 5) ||
        op_pre(b, len, "movzl", 5) || op_pre(b, len, "movsl", 5)) begin
      cls = CLS_MOVE;
    end else if (op_is(b, len, "add", 3) || op_is(b, len, "sub", 3) ||
        op_is(b, len, "mul", 3) || op_is(b, len, "imul", 4) || op_is(b, len, "div", 3) ||
        op_is(b, len, "idiv", 4) || op_is(b, len, "inc", 3) || op_is(b, len, "dec", 3) ||
        op_is(b, len, "neg", 3) || op_is(b, len, "not", 3) || op_is(b, len, "and", 3) ||
        op_is(b, len, "or", 2) || op_is(b, len, "xor", 3) || op_is(b, len, "sh", 2) ||
        op_is(b, len, "shr", 3) || op_is(b, len, "shl", 3) || op_is(b, len, "sar", 3) ||
        op_is(b, len, "sal", 3) || op_is(b, len, "adc", 3) || op_is(b, len, "sbb", 3) ||
        op_is(b, len, "ror", 3) || op_is(b, len, "rol", 3) || op_is(b, len, "cmp", 3) ||
        op_is(b, len, "test", 4) || op_pre(b, len, "set", 3)) begin
      cls = CLS_ARITH;
    end else if (op_pre(b, len, "j", 1) || op_is(b, len, "call", 4) ||
        op_is(b, len, "ret", 3) || op_is(b, len, "loop", 4)) begin
      cls = CLS_CTRL;
    end else begin
      cls = CLS_OTHER;
    end
  end

  always_comb begin
    text = '0;
    for (int i = 0; i < OPCODE_OUT_CHARS; i++) begin
      if (OPLEN_BITS'(i) < len) text[8*i +: 8] = q_head.op_buf[i];
    end
  end

  // An opcode result is emitted only below the limit and only on the first pass.
  assign emit_op = !pend_r && q_head.has_opcode && (emit_r < op_limit);
  assign q_pop   = !q_empty && slot_free && !(emit_op && q_head.summary);
  assign take    = !q_empty && slot_free;
  // The record finishes the text here and clears the counters.
  assign fin     = q_head.summary && !emit_op;

  // Counter values once the head record's line is counted.
  always_comb begin
    insn_upd = insn_r;
    mov_upd  = mov_r;
    ari_upd  = ari_r;
    ctl_upd  = ctl_r;
    oth_upd  = oth_r;
    tot_upd  = tot_r;
    emit_upd = emit_r;
    if (!pend_r) begin
      if (q_head.count_insn) insn_upd = sat_inc(insn_r);
      if (q_head.has_opcode) begin
        tot_upd = sat_inc(tot_r);
        case (cls)
          CLS_MOVE:  mov_upd = sat_inc(mov_r);
          CLS_ARITH: ari_upd = sat_inc(ari_r);
          CLS_CTRL:  ctl_upd = sat_inc(ctl_r);
          default:   oth_upd = sat_inc(oth_r);
        endcase
        if (emit_op) emit_upd = sat_inc(emit_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      insn_r <= '0; mov_r <= '0; ari_r <= '0; ctl_r <= '0;
      oth_r  <= '0; tot_r <= '0; emit_r <= '0;
      pend_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (slot_free) ov_r <= !q_empty && (emit_op || q_head.summary);
      if (take) begin
        if (fin) begin
          insn_r <= '0; mov_r <= '0; ari_r <= '0; ctl_r <= '0;
          oth_r  <= '0; tot_r <= '0; emit_r <= '0;
        end else begin
          insn_r <= insn_upd; mov_r <= mov_upd; ari_r <= ari_upd; ctl_r <= ctl_upd;
          oth_r  <= oth_upd;  tot_r <= tot_upd; emit_r <= emit_upd;
        end
        if (emit_op) pend_r <= q_head.summary;
        else if (q_head.summary) pend_r <= 1'b0;
      end
    end
  end

  // Output register; the summary reads counters that include this record's opcode.
  always_ff @(posedge clk) begin
    if (take && (emit_op || q_head.summary)) begin
      kind_r  <= !emit_op;
      text_r  <= emit_op ? text : '0;
      cls_r   <= emit_op ? cls : CLS_MOVE;
      found_r <= emit_op ? 1'b1 : q_head.found;
      last_r  <= emit_op ? !q_head.summary : 1'b1;
      ic_r    <= emit_op ? '0 : insn_upd;
      mc_r    <= emit_op ? '0 : mov_upd;
      ac_r    <= emit_op ? '0 : ari_upd;
      cc_r    <= emit_op ? '0 : ctl_upd;
      oc_r    <= emit_op ? '0 : oth_upd;
      tc_r    <= emit_op ? '0 : tot_upd;
    end
  end

  assign out_valid             = ov_r;
  assign out_item_kind         = kind_r;
  assign out_opcode_text       = text_r;
  assign out_opcode_class      = cls_r;
  assign out_function_found    = found_r;
  assign out_instruction_count = ic_r;
  assign out_mov_count         = mc_r;
  assign out_arith_count       = ac_r;
  assign out_control_count     = cc_r;
  assign out_other_count       = oc_r;
  assign out_opcode_total      = tc_r;
  assign out_last_item         = last_r;

  // A stalled result stays in place.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && out_stall |=> ov_r && $stable(text_r) && $stable(kind_r))
    else $error("stalled result changed");
  // The second pass only exists for a summary record.
  a_pend: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (!q_empty && q_head.summary)) else $error("pending with no summary");
  // Emitted count never exceeds the opcode total.
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit_r <= tot_r) else $error("emitted above total");

endmodule

[rtl/asm_function_insn_classifier_unit.sv]
// Top level of the assembly function instruction classifier.
// Depends on afic_pkg, afic_front, afic_queue and afic_back.
//
// Usage: text bytes enter on the in_ channel (in_valid, in_stall,
// in_text_byte, in_last_byte), one byte per cycle. The front part walks the
// line state and, at each body line end or final byte, pushes one record
// into a four-entry queue. The back part strips suffixes, classifies the
// opcode, updates saturating counters and presents results on the out_
// channel through a single output register.
// Throughput: one byte per cycle while in_stall is low. The back part handles
// a record in one pass, or in an opcode pass and then a summary pass when the
// final byte both emits an opcode result and asks for the summary.
// Configuration (cfg_we, cfg_index, cfg_wdata) must be written only while idle;
// the block does not enforce it. Reset clears all scan state and counters and
// loads the register defaults. When the receiver stalls, the result holds, the
// queue fills, and in_stall rises once it is full; no byte or result is lost.
module asm_function_insn_classifier_unit
  import afic_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_last_byte,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_item_kind,
  output logic [55:0] out_opcode_text,
  output logic [1:0]  out_opcode_class,
  output logic        out_function_found,
  output logic [15:0] out_instruction_count,
  output logic [15:0] out_mov_count,
  output logic [15:0] out_arith_count,
  output logic [15:0] out_control_count,
  output logic [15:0] out_other_count,
  output logic [15:0] out_opcode_total,
  output logic        out_last_item
);

  logic [63:0] name_low_r, name_high_r;
  logic [4:0]  name_len_r;
  logic [15:0] op_limit_r;

  logic      q_full, q_empty, q_push, q_pop;
  line_rec_t q_in, q_head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_low_r  <= '0;
      name_high_r <= '0;
      name_len_r  <= 5'd1;
      op_limit_r  <= 16'hffff;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NAME_LOW:  name_low_r  <= cfg_wdata;
        REG_NAME_HIGH: name_high_r <= cfg_wdata;
        REG_NAME_LEN:  name_len_r  <= cfg_wdata[4:0];
        REG_OP_LIMIT:  op_limit_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  afic_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_text_byte, .in_last_byte,
    .name_low(name_low_r), .name_high(name_high_r), .name_len(name_len_r),
    .q_full, .q_push, .q_data(q_in)
  );

  afic_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .empty(q_empty), .head(q_head)
  );

  afic_back u_back (
    .clk, .rst_n, .op_limit(op_limit_r), .q_empty, .q_head, .q_pop,
    .out_valid, .out_stall, .out_item_kind, .out_opcode_text, .out_opcode_class,
    .out_function_found, .out_instruction_count, .out_mov_count, .out_arith_count,
    .out_control_count, .out_other_count, .out_opcode_total, .out_last_item
  );

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_full) else $error("input stalled with room in queue");
  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_kind |-> out_last_item) else $error("summary not last");
  a_op_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item_kind |-> out_function_found) else $error("opcode without label");

endmodule
